// ===== src/mcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared types, codes and constants of the Mohr-Coulomb bond failure unit.
// ----------------------------------------------------------------------------
package mcbf_pkg;

  // stress and trig formats
  localparam int STRESS_W = 32;
  localparam int SUM_W    = 33;   // sum of two end stresses
  localparam int CTR_W    = 34;   // centre F = X + Y
  localparam int MAG_W    = 34;   // |X - Y| and 2|Z|
  localparam int SQ_W     = 68;   // one square
  localparam int RAD_W    = 69;   // radicand (sum of squares)
  localparam int ROOT_W   = 36;   // root bits resolved, one per stage
  localparam int REM_W    = 40;   // partial remainder
  localparam int QSH_W    = 2 * ROOT_W;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // failure cause codes
  localparam logic [1:0] CAUSE_INTACT  = 2'd0;
  localparam logic [1:0] CAUSE_SHEAR   = 2'd1;
  localparam logic [1:0] CAUSE_TENSILE = 2'd2;
  localparam logic [1:0] CAUSE_SKIP    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_COHESION = 3'd0;
  localparam logic [2:0] REG_FRICTION = 3'd1;
  localparam logic [2:0] REG_TENSILE  = 3'd2;
  localparam logic [2:0] REG_SIN      = 3'd3;
  localparam logic [2:0] REG_COS      = 3'd4;

  // item handed from front to back
  typedef struct packed {
    logic                    skip;
    logic                    intact;
    logic signed [CTR_W-1:0] ctr;
    logic [RAD_W-1:0]        rad;
  } mcbf_mid_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [30:0]        cohesion;
    logic [15:0]        friction_coef;
    logic [30:0]        tensile_strength;
    logic signed [15:0] sin_angle;
    logic signed [15:0] cos_angle;
  } mcbf_cfg_t;

endpackage

// ===== src/mcbf_bond_if.sv =====
// ----------------------------------------------------------------------------
// mcbf_bond_if
// Input channel: one bond item with both end stresses and flags.
// ----------------------------------------------------------------------------
interface mcbf_bond_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] stress_xx_i;
  logic signed [31:0] stress_yy_i;
  logic signed [31:0] stress_xy_i;
  logic signed [31:0] stress_xx_j;
  logic signed [31:0] stress_yy_j;
  logic signed [31:0] stress_xy_j;
  logic               fixed_i;
  logic               fixed_j;
  logic               bond_intact;

  modport source (output valid, stress_xx_i, stress_yy_i, stress_xy_i, stress_xx_j,
                  stress_yy_j, stress_xy_j, fixed_i, fixed_j, bond_intact,
                  input ready);
  modport sink (input valid, stress_xx_i, stress_yy_i, stress_xy_i, stress_xx_j,
                stress_yy_j, stress_xy_j, fixed_i, fixed_j, bond_intact,
                output ready);
endinterface

// ===== src/mcbf_res_if.sv =====
// ----------------------------------------------------------------------------
// mcbf_res_if
// Result channel: evaluated bond flags and failure cause.
// ----------------------------------------------------------------------------
interface mcbf_res_if;
  logic       valid;
  logic       ready;
  logic       bond_intact_out;
  logic       broke_now;
  logic [1:0] cause;

  modport source (output valid, bond_intact_out, broke_now, cause, input ready);
  modport sink (input valid, bond_intact_out, broke_now, cause, output ready);
endinterface

// ===== src/mcbf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mcbf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mcbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/mohr_coulomb_bond_failure_unit.sv =====
// ----------------------------------------------------------------------------
// mohr_coulomb_bond_failure_unit
// Mohr-Coulomb bond failure check with tensile cutoff, one 2D bond per item.
// ----------------------------------------------------------------------------
// Usage:
//   bond   - input items: both end stresses, unbreakable flags, connected flag.
//   result - one item per bond: connected flag, broke flag and failure cause.
//   cfg    - register writes (cohesion, friction, tensile strength, sin, cos);
//            always ready, write only while the block is idle.
// Throughput: one bond per cycle unless the receiver stalls. The front
// (sums, magnitudes, squares) and the back (36-stage square root, one root
// bit per stage, then four stages of plane stresses and the decision) are
// parted by a short queue. On the way to result valid, the accepting edge
// loads the first of 3 front stages, then 1 queue slot, 1 back input stage,
// 36 root stages, 4 evaluation stages and the output register.
// Skipped bonds travel the same pipeline so results keep input order.
// Reset clears all valid flags and loads the register defaults (cos = 32767).
// When the receiver stalls, the back holds; the queue fills, then the front
// stops and bond.ready drops. Items are never lost or repeated.
// ----------------------------------------------------------------------------
module mohr_coulomb_bond_failure_unit
  import mcbf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mcbf_bond_if.sink   bond,
  mcbf_res_if.source  result,
  mcbf_cfg_if.sink    cfg
);

  mcbf_cfg_t cfg_regs;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  mcbf_mid_t push_data, pop_data;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.cohesion         <= '0;
      cfg_regs.friction_coef    <= '0;
      cfg_regs.tensile_strength <= '0;
      cfg_regs.sin_angle        <= '0;
      cfg_regs.cos_angle        <= 16'sd32767;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_COHESION: cfg_regs.cohesion         <= cfg.data[30:0];
        REG_FRICTION: cfg_regs.friction_coef    <= cfg.data[15:0];
        REG_TENSILE:  cfg_regs.tensile_strength <= cfg.data[30:0];
        REG_SIN:      cfg_regs.sin_angle        <= cfg.data[15:0];
        REG_COS:      cfg_regs.cos_angle        <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  mcbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bond       (bond),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mcbf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mcbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

  // a broken bond is disconnected and carries a failure cause
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.broke_now |->
      !result.bond_intact_out &&
      (result.cause == CAUSE_SHEAR || result.cause == CAUSE_TENSILE))
    else $error("broken bond with wrong flags");

  // an unbroken bond is either intact or skipped
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.broke_now |->
      (result.cause == CAUSE_INTACT || result.cause == CAUSE_SKIP))
    else $error("unbroken bond with failure cause");

  // no result right after reset
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !result.valid)
    else $error("result valid after reset");

endmodule

// ===== src/mcbf_front.sv =====
// ----------------------------------------------------------------------------
// mcbf_front
// Accepts bonds, classifies skips, forms centre and the radius radicand.
// ----------------------------------------------------------------------------
module mcbf_front
  import mcbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  mcbf_bond_if.sink         bond,
  output logic              push_valid,
  input  logic              push_ready,
  output mcbf_mid_t         push_data
);

  // stage A: sums of the two ends
  logic                    av, a_skip, a_int;
  logic signed [SUM_W-1:0] ax, ay, az;
  // stage B: centre and magnitudes
  logic                    bv, b_skip, b_int;
  logic signed [CTR_W-1:0] b_ctr;
  logic [MAG_W-1:0]        b_dx, b_dz;
  // stage C: squares
  logic                    cv, c_skip, c_int;
  logic signed [CTR_W-1:0] c_ctr;
  logic [SQ_W-1:0]         c_s1, c_s2;

  logic                    adv;
  logic signed [CTR_W-1:0] dxy;
  logic [MAG_W-1:0]        zmag;

  // whole front moves together unless the last stage is blocked
  assign adv        = !cv || push_ready;
  assign bond.ready = adv;

  assign dxy  = CTR_W'(ax) - CTR_W'(ay);
  assign zmag = az[SUM_W-1] ? MAG_W'(-CTR_W'(az)) : MAG_W'(az);

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
      bv <= 1'b0;
      cv <= 1'b0;
    end else if (adv) begin
      av <= bond.valid;
      bv <= av;
      cv <= bv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_skip <= bond.fixed_i || bond.fixed_j || !bond.bond_intact;
      a_int  <= bond.bond_intact;
      ax <= SUM_W'(bond.stress_xx_i) + SUM_W'(bond.stress_xx_j);
      ay <= SUM_W'(bond.stress_yy_i) + SUM_W'(bond.stress_yy_j);
      az <= SUM_W'(bond.stress_xy_i) + SUM_W'(bond.stress_xy_j);

      b_skip <= a_skip;
      b_int  <= a_int;
      b_ctr  <= CTR_W'(ax) + CTR_W'(ay);
      b_dx   <= dxy[CTR_W-1] ? MAG_W'(-dxy) : MAG_W'(dxy);
      b_dz   <= {zmag[MAG_W-2:0], 1'b0};

      c_skip <= b_skip;
      c_int  <= b_int;
      c_ctr  <= b_ctr;
      c_s1   <= SQ_W'(b_dx) * SQ_W'(b_dx);
      c_s2   <= SQ_W'(b_dz) * SQ_W'(b_dz);
    end
  end

  assign push_valid       = cv;
  assign push_data.skip   = c_skip;
  assign push_data.intact = c_int;
  assign push_data.ctr    = c_ctr;
  assign push_data.rad    = RAD_W'(c_s1) + RAD_W'(c_s2);

endmodule

// ===== src/mcbf_queue.sv =====
// ----------------------------------------------------------------------------
// mcbf_queue
// Short FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module mcbf_queue
  import mcbf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  mcbf_mid_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output mcbf_mid_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mcbf_mid_t       mem [DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [CW-1:0]   count;
  logic            wr, rd;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rp];
  assign wr         = push_valid && push_ready;
  assign rd         = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + CW'(wr) - CW'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= push_data;
  end

endmodule

// ===== src/mcbf_back.sv =====
// ----------------------------------------------------------------------------
// mcbf_back
// Pipelined square root, failure plane stresses and the failure decision.
// ----------------------------------------------------------------------------
module mcbf_back
  import mcbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mcbf_cfg_t cfg,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  mcbf_mid_t pop_data,
  mcbf_res_if.source result
);

  localparam int NS = ROOT_W;

  // square root pipeline, one root bit per stage
  logic                    sv    [NS+1];
  logic                    sskip [NS+1];
  logic                    sint  [NS+1];
  logic signed [CTR_W-1:0] sctr  [NS+1];
  logic [QSH_W-1:0]        sq    [NS+1];
  logic [REM_W-1:0]        srem  [NS+1];
  logic [ROOT_W-1:0]       sroot [NS+1];

  logic adv;

  assign adv       = !result.valid || result.ready;
  assign pop_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (adv) sv[0] <= pop_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sskip[0] <= pop_data.skip;
      sint[0]  <= pop_data.intact;
      sctr[0]  <= pop_data.ctr;
      sq[0]    <= QSH_W'(pop_data.rad);
      srem[0]  <= '0;
      sroot[0] <= '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_n, trial;
    logic             ge;

    // bring down the next bit pair, try root*4+1
    assign rem_n = {srem[k][REM_W-3:0], sq[k][QSH_W-1 -: 2]};
    assign trial = {{(REM_W-ROOT_W-2){1'b0}}, sroot[k], 2'b01};
    assign ge    = rem_n >= trial;

    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (adv) sv[k+1] <= sv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sskip[k+1] <= sskip[k];
        sint[k+1]  <= sint[k];
        sctr[k+1]  <= sctr[k];
        sq[k+1]    <= {sq[k][QSH_W-3:0], 2'b00};
        srem[k+1]  <= ge ? rem_n - trial : rem_n;
        sroot[k+1] <= {sroot[k][ROOT_W-2:0], ge};
      end
    end
  end

  // E1: shear, radius times cosine, tensile test
  logic               e1v, e1_skip, e1_int, e1_tens;
  logic signed [CTR_W-1:0] e1_ctr;
  logic [51:0]        e1_sh;
  logic signed [52:0] e1_rc;
  // E2: normal stress rounded down to whole units of F (0 fraction bits)
  logic               e2v, e2_skip, e2_int, e2_tens;
  logic [51:0]        e2_sh;
  logic signed [38:0] e2_nq;
  // E3: friction term
  logic               e3v, e3_skip, e3_int, e3_tens;
  logic [51:0]        e3_sh;
  logic signed [55:0] e3_fm;
  // E4: M
  logic               e4v, e4_skip, e4_int, e4_tens;
  logic [51:0]        e4_sh;
  logic signed [56:0] e4_m;

  logic signed [ROOT_W:0] r_s;
  logic [15:0]            sin_mag;
  logic signed [37:0]     fr_sum, ts4;
  logic [56:0]            m_mag;
  logic                   shear;
  logic                   o_valid, o_int, o_broke;
  logic [1:0]             o_cause;

  assign r_s     = {1'b0, sroot[NS]};
  assign sin_mag = cfg.sin_angle[15] ? 16'(-cfg.sin_angle) : 16'(cfg.sin_angle);
  assign fr_sum  = 38'(sctr[NS]) + 38'(r_s);
  assign ts4     = $signed({5'b0, cfg.tensile_strength, 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      e1v     <= 1'b0;
      e2v     <= 1'b0;
      e3v     <= 1'b0;
      e4v     <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      e1v     <= sv[NS];
      e2v     <= e1v;
      e3v     <= e2v;
      e4v     <= e3v;
      o_valid <= e4v;
    end
  end

  logic signed [53:0] nrm_e2;
  assign nrm_e2 = (54'(e1_ctr) <<< 15) - 54'(e1_rc);
  assign m_mag  = e4_m[56] ? 57'(-e4_m) : 57'(e4_m);
  assign shear  = {8'b0, e4_sh} >= {m_mag, 3'b000};

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_skip <= sskip[NS];
      e1_int  <= sint[NS];
      e1_ctr  <= sctr[NS];
      e1_sh   <= 52'(sroot[NS]) * 52'(sin_mag);
      e1_rc   <= 53'(r_s) * 53'(cfg.cos_angle);
      e1_tens <= fr_sum >= ts4;

      e2_skip <= e1_skip;
      e2_int  <= e1_int;
      e2_tens <= e1_tens;
      e2_sh   <= e1_sh;
      e2_nq   <= 39'(nrm_e2 >>> 15);

      e3_skip <= e2_skip;
      e3_int  <= e2_int;
      e3_tens <= e2_tens;
      e3_sh   <= e2_sh;
      e3_fm   <= 56'($signed({1'b0, cfg.friction_coef})) * 56'(e2_nq);

      e4_skip <= e3_skip;
      e4_int  <= e3_int;
      e4_tens <= e3_tens;
      e4_sh   <= e3_sh;
      e4_m    <= $signed({12'b0, cfg.cohesion, 14'b0}) - 57'(e3_fm);

      // decision and output register
      if (e4_skip) begin
        o_int   <= e4_int;
        o_broke <= 1'b0;
        o_cause <= CAUSE_SKIP;
      end else if (shear) begin
        o_int   <= 1'b0;
        o_broke <= 1'b1;
        o_cause <= CAUSE_SHEAR;
      end else if (e4_tens) begin
        o_int   <= 1'b0;
        o_broke <= 1'b1;
        o_cause <= CAUSE_TENSILE;
      end else begin
        o_int   <= 1'b1;
        o_broke <= 1'b0;
        o_cause <= CAUSE_INTACT;
      end
    end
  end

  assign result.valid           = o_valid;
  assign result.bond_intact_out = o_int;
  assign result.broke_now       = o_broke;
  assign result.cause           = o_cause;

endmodule
